/* hw/rtl/rlz_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the range add / last zero store.
// No dependencies; imported by every module of the block.
package rlz_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned ValW        = 11;
  localparam int unsigned PtrW        = 11;
  localparam int unsigned DeltaW      = 12;

  localparam logic [PtrW-1:0] SizeReset = PtrW'(MaxElements);
  localparam logic [PtrW-1:0] LastAddr  = PtrW'(MaxElements - 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_FIND = 2'd2,
    OP_BAD  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [IdxW-1:0]          element_index;
    logic [ValW-1:0]          load_value;
    logic [PtrW-1:0]          range_start;
    logic [PtrW-1:0]          range_end;
    logic signed [DeltaW-1:0] delta;
    logic [PtrW-1:0]          search_bound;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] zero_index;
    logic            found;
    logic            error;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_APP_RD,
    ST_APP_WR,
    ST_FND_RD,
    ST_FND_EV,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic load_wr;
    logic add_wr;
    logic rd;
    logic rd_prev;
    logic ptr_clr;
    logic ptr_rs;
    logic ptr_bound;
    logic ptr_inc;
    logic ptr_dec;
    logic set_err;
    logic set_found;
    logic res_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic idx_bad;
    logic range_bad;
    logic range_empty;
    logic ptr_at_end;
    logic ptr_zero;
    logic ptr_last;
    logic val_bad;
    logic val_zero;
    logic res_free;
  } stat_t;

endpackage

/* hw/rtl/rlz_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the range add / last zero store: sequences each request.
// Depends on rlz_pkg.
module rlz_ctrl import rlz_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.ptr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_ADD: begin
            if (stat_i.range_bad || stat_i.range_empty) state_d = ST_DONE;
            else state_d = ST_CHK_RD;
          end
          OP_FIND: state_d = ST_FND_RD;
          default: state_d = ST_DONE;
        endcase
      end
      ST_CHK_RD: state_d = stat_i.ptr_at_end ? ST_APP_RD : ST_CHK_EV;
      ST_CHK_EV: state_d = stat_i.val_bad ? ST_DONE : ST_CHK_RD;
      ST_APP_RD: state_d = stat_i.ptr_at_end ? ST_DONE : ST_APP_WR;
      ST_APP_WR: state_d = ST_APP_RD;
      ST_FND_RD: state_d = stat_i.ptr_zero ? ST_DONE : ST_FND_EV;
      ST_FND_EV: state_d = stat_i.val_zero ? ST_DONE : ST_FND_RD;
      ST_DONE:   if (stat_i.res_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr_wr  = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_LOAD: begin
            ctrl_o.set_err = stat_i.idx_bad;
            ctrl_o.load_wr = !stat_i.idx_bad;
          end
          OP_ADD: begin
            ctrl_o.set_err = stat_i.range_bad;
            ctrl_o.ptr_rs  = 1'b1;
          end
          OP_FIND: ctrl_o.ptr_bound = 1'b1;
          default: ctrl_o.set_err = 1'b1;
        endcase
      end
      ST_CHK_RD: begin
        if (stat_i.ptr_at_end) ctrl_o.ptr_rs = 1'b1;
        else ctrl_o.rd = 1'b1;
      end
      ST_CHK_EV: begin
        if (stat_i.val_bad) ctrl_o.set_err = 1'b1;
        else ctrl_o.ptr_inc = 1'b1;
      end
      ST_APP_RD: if (!stat_i.ptr_at_end) ctrl_o.rd = 1'b1;
      ST_APP_WR: begin
        ctrl_o.add_wr  = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
      end
      ST_FND_RD: begin
        if (!stat_i.ptr_zero) begin
          ctrl_o.rd      = 1'b1;
          ctrl_o.rd_prev = 1'b1;
          ctrl_o.ptr_dec = 1'b1;
        end
      end
      ST_FND_EV: if (stat_i.val_zero) ctrl_o.set_found = 1'b1;
      ST_DONE:   ctrl_o.res_load = stat_i.res_free;
      default:   ctrl_o.ptr_clr = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/rlz_dp.sv */
`timescale 1ns / 1ps
// Datapath: element memory, sweep pointer, request and result registers.
// Depends on rlz_pkg; driven by rlz_ctrl.
module rlz_dp import rlz_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [PtrW-1:0] cfg_wdata_i,
  input  req_t            in_req_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output rsp_t            out_rsp_o,
  input  ctrl_t           ctrl_i,
  output stat_t           stat_o
);

  logic [ValW-1:0] mem_q [MaxElements];

  logic [PtrW-1:0] size_q, n;
  logic [PtrW-1:0] ptr_q, ptr_d, bound;
  req_t            req_q;
  logic [ValW-1:0] rd_q;
  logic            err_q, err_d, found_q, found_d;
  logic            res_valid_q, res_valid_d;
  rsp_t            res_q;
  logic [PtrW-1:0] ptr_m1;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [ValW-1:0] wr_data;
  logic            wr_en;
  logic signed [ValW+1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (size_q == '0) n = PtrW'(1);
    else if (size_q > SizeReset) n = SizeReset;
    else n = size_q;
  end

  assign bound  = (req_q.search_bound > n) ? n : req_q.search_bound;
  assign ptr_m1 = ptr_q - PtrW'(1);
  assign sum    = $signed({2'b00, rd_q}) + (ValW+2)'(req_q.delta);

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_clr) ptr_d = '0;
    else if (ctrl_i.ptr_rs) ptr_d = req_q.range_start;
    else if (ctrl_i.ptr_bound) ptr_d = bound;
    else if (ctrl_i.ptr_inc) ptr_d = (ptr_q == LastAddr && ctrl_i.clr_wr) ? '0
                                                                           : ptr_q + PtrW'(1);
    else if (ctrl_i.ptr_dec) ptr_d = ptr_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) req_q <= in_req_i;
  end

  // single port style memory: one write, one registered read per cycle
  assign rd_addr = ctrl_i.rd_prev ? ptr_m1[IdxW-1:0] : ptr_q[IdxW-1:0];
  assign wr_addr = ctrl_i.load_wr ? req_q.element_index : ptr_q[IdxW-1:0];
  assign wr_en   = ctrl_i.clr_wr | ctrl_i.load_wr | ctrl_i.add_wr;

  always_comb begin
    wr_data = '0;
    if (ctrl_i.load_wr) wr_data = req_q.load_value;
    else if (ctrl_i.add_wr) wr_data = sum[ValW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (ctrl_i.rd) rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    err_d   = err_q;
    found_d = found_q;
    if (ctrl_i.capture) begin
      err_d   = 1'b0;
      found_d = 1'b0;
    end
    if (ctrl_i.set_err) err_d = 1'b1;
    if (ctrl_i.set_found) found_d = 1'b1;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (ctrl_i.res_load) res_valid_d = 1'b1;
    else if (out_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      err_q       <= err_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_q.error      <= err_q;
      res_q.found      <= found_q;
      res_q.zero_index <= found_q ? ptr_q[IdxW-1:0] : '0;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_rsp_o   = res_q;

  assign stat_o.op          = op_e'(req_q.opcode);
  assign stat_o.idx_bad     = {1'b0, req_q.element_index} >= n;
  assign stat_o.range_bad   = (req_q.range_start > n) || (req_q.range_end > n);
  assign stat_o.range_empty = req_q.range_start >= req_q.range_end;
  assign stat_o.ptr_at_end  = ptr_q == req_q.range_end;
  assign stat_o.ptr_zero    = ptr_q == '0;
  assign stat_o.ptr_last    = ptr_q == LastAddr;
  // below zero or above the value range
  assign stat_o.val_bad     = sum[ValW+1] | sum[ValW];
  assign stat_o.val_zero    = rd_q == '0;
  assign stat_o.res_free    = !res_valid_q || out_ready_i;

endmodule

/* hw/rtl/range_add_min_tree_last_zero_unit.sv */
`timescale 1ns / 1ps
// Top level of the range add / last zero store: controller plus datapath.
// Depends on rlz_pkg, rlz_ctrl, rlz_dp.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   request | in_valid_i/in_ready_o/in_req_i | in
//   result  | out_valid_o/out_ready_i/out_rsp_o | out
//   config  | cfg_we_i/cfg_wdata_i           | in
//
// One request at a time. Load, bad opcode, bad or empty range: straight from
// decode to done. Find reads down from the bound to a zero or to element 0.
// Add: a check sweep then an apply sweep; a value out of range ends the check
// sweep early. Each element is read, then used. After reset a clearing pass
// writes zero to every element before the first request is taken.
// A new result waits in the done state until the previous one has drained.
module range_add_min_tree_last_zero_unit import rlz_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [PtrW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  rlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rlz_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

/* hw/rtl/rlz_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for range_add_min_tree_last_zero_unit, with its bind.
// Depends on rlz_pkg.
module rlz_checker import rlz_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_found_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> !out_rsp_o.error)
    else $error("found and error together");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |-> out_rsp_o.zero_index == '0)
    else $error("index set without a find");

endmodule

bind range_add_min_tree_last_zero_unit rlz_checker u_rlz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
